// ===== src/rusi_pkg.sv =====
// Package for the ray against unit square intersection block.
// Holds payload structs, register indexes, pipeline sizes and arithmetic helpers.
// No dependencies.
package rusi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_CFG       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_A    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_B    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_XY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z  = 3'd7;

  localparam int QUEUE_DEPTH = 2;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 64;
  localparam int NUM_QUO     = 6;
  localparam int Q_X    = 0;
  localparam int Q_Y    = 1;
  localparam int Q_HX   = 2;
  localparam int Q_HY   = 3;
  localparam int Q_HZ   = 4;
  localparam int Q_DIST = 5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } result_t;

  typedef logic [2:0][3:0][31:0] mat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } normal_t;

  typedef struct packed {
    logic               miss;
    ray_t               ray;
    logic signed [31:0] po_x;
    logic signed [31:0] po_y;
    logic signed [31:0] po_z;
    logic signed [31:0] pd_x;
    logic signed [31:0] pd_y;
    logic signed [31:0] pd_z;
  } mid_t;

  typedef struct packed {
    logic                         miss;
    logic signed [31:0]           o_x;
    logic signed [31:0]           o_y;
    logic signed [31:0]           o_z;
    logic signed [31:0]           po_x;
    logic signed [31:0]           po_y;
    logic [NUM_QUO-2:0]           neg;
    logic [NUM_QUO-2:0][63:0]     num;
    logic [31:0]                  aoz;
    logic [31:0]                  adz;
  } side1_t;

  typedef struct packed {
    logic               miss;
    logic signed [31:0] o_x;
    logic signed [31:0] o_y;
    logic signed [31:0] o_z;
    logic signed [31:0] po_x;
    logic signed [31:0] po_y;
    logic [NUM_QUO-2:0] neg;
  } side2_t;

  function automatic logic signed [63:0] mul_s32(logic signed [31:0] a, logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic [63:0] mul_u32(logic [31:0] a, logic [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  function automatic logic [31:0] abs32(logic signed [31:0] a);
    return a[31] ? 32'(-a) : 32'(a);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== src/rusi_queue.sv =====
// Small first-in first-out queue used between pipeline sections.
// Depends on rusi_pkg for the default depth.
module rusi_queue import rusi_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] wrap(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/rusi_div.sv =====
// Pipelined restoring divider, 64-bit unsigned dividend by 32-bit divisor.
// One quotient bit per stage; depends on rusi_pkg for the stage count.
module rusi_div import rusi_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [63:0] quo
);

  logic [63:0] rq  [DIV_STAGES];
  logic [31:0] rem [DIV_STAGES];
  logic [31:0] dv  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [63:0] rq_in;
    logic [31:0] rem_in;
    logic [31:0] dv_in;
    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rq_in  = num;
      assign rem_in = '0;
      assign dv_in  = den;
    end else begin : g_rest
      assign rq_in  = rq[k-1];
      assign rem_in = rem[k-1];
      assign dv_in  = dv[k-1];
    end

    assign sh   = {rem_in, rq_in[63]};
    assign diff = sh - {1'b0, dv_in};
    assign ge   = (sh >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rq[k]  <= {rq_in[62:0], ge};
        rem[k] <= ge ? diff[31:0] : sh[31:0];
        dv[k]  <= dv_in;
      end
    end
  end

  assign quo = rq[DIV_STAGES-1];

endmodule

// ===== src/rusi_sqrt.sv =====
// Pipelined floor square root of a 64-bit unsigned value.
// Two radicand bits per stage; depends on rusi_pkg for the stage count.
module rusi_sqrt import rusi_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] val [SQRT_STAGES];
  logic [32:0] rem [SQRT_STAGES];
  logic [31:0] rt  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic [63:0] val_in;
    logic [32:0] rem_in;
    logic [31:0] rt_in;
    logic [34:0] sh;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign val_in = rad;
      assign rem_in = '0;
      assign rt_in  = '0;
    end else begin : g_rest
      assign val_in = val[k-1];
      assign rem_in = rem[k-1];
      assign rt_in  = rt[k-1];
    end

    assign sh    = {rem_in, val_in[63:62]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign diff  = sh - trial;
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        val[k] <= {val_in[61:0], 2'b00};
        rem[k] <= ge ? diff[32:0] : sh[32:0];
        rt[k]  <= {rt_in[30:0], ge};
      end
    end
  end

  assign root = rt[SQRT_STAGES-1];

endmodule

// ===== src/rusi_front.sv =====
// Front section: maps the world ray into object space and classifies it.
// Depends on rusi_pkg; feeds the middle queue.
module rusi_front import rusi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  ray_t ray,
  input  mat_t mat,
  output logic mid_push,
  output mid_t mid,
  input  logic mid_full
);

  logic               adv;
  logic               p_vld;
  ray_t               p_ray;
  logic signed [63:0] prod_o [3][3];
  logic signed [63:0] prod_d [3][3];
  logic               s_vld;
  mid_t               s_mid;
  logic signed [31:0] o_vec [3];
  logic signed [31:0] d_vec [3];
  logic signed [31:0] po [3];
  logic signed [31:0] pd [3];
  logic               miss;

  assign adv      = !s_vld || !mid_full;
  assign full     = !adv;
  assign mid_push = s_vld && !mid_full;
  assign mid      = s_mid;

  assign o_vec[0] = ray.origin_x;
  assign o_vec[1] = ray.origin_y;
  assign o_vec[2] = ray.origin_z;
  assign d_vec[0] = ray.dir_x;
  assign d_vec[1] = ray.dir_y;
  assign d_vec[2] = ray.dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      s_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= push;
      s_vld <= p_vld;
    end
  end

  always_comb begin
    logic signed [63:0] so;
    logic signed [63:0] sd;
    for (int r = 0; r < 3; r++) begin
      so = 64'($signed(mat[r][3]));
      sd = '0;
      for (int c = 0; c < 3; c++) begin
        so = so + (prod_o[r][c] >>> FRAC_BITS);
        sd = sd + (prod_d[r][c] >>> FRAC_BITS);
      end
      po[r] = sat32(so);
      pd[r] = sat32(sd);
    end
  end

  assign miss = (pd[2] == '0) || ((po[2] != '0) && (po[2][31] == pd[2][31]));

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ray <= ray;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_o[r][c] <= mul_s32($signed(mat[r][c]), o_vec[c]);
          prod_d[r][c] <= mul_s32($signed(mat[r][c]), d_vec[c]);
        end
      end
      s_mid.miss <= miss;
      s_mid.ray  <= p_ray;
      s_mid.po_x <= po[0];
      s_mid.po_y <= po[1];
      s_mid.po_z <= po[2];
      s_mid.pd_x <= pd[0];
      s_mid.pd_y <= pd[1];
      s_mid.pd_z <= pd[2];
    end
  end

endmodule

// ===== src/rusi_back.sv =====
// Back section: crossing point, hit point, distance and texture coordinates.
// Depends on rusi_pkg, rusi_sqrt and rusi_div; drains the middle queue.
module rusi_back import rusi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    mid_empty,
  input  mid_t    mid,
  output logic    mid_pop,
  input  normal_t normal,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic                   en;
  logic                   a_vld;
  mid_t                   a;
  logic                   b_vld;
  side1_t                 b;
  logic [63:0]            b_sq [3];
  logic [63:0]            rad;
  logic [31:0]            root;
  side1_t                 s1 [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] v1;
  logic                   m_vld;
  side2_t                 m;
  logic [63:0]            m_num [NUM_QUO];
  logic [31:0]            m_den;
  logic [63:0]            quo [NUM_QUO];
  side2_t                 s2 [DIV_STAGES];
  logic [DIV_STAGES-1:0]  v2;
  side2_t                 t;
  logic signed [63:0]     qs [NUM_QUO-1];
  logic signed [63:0]     x;
  logic signed [63:0]     y;
  logic [79:0]            tu;
  logic [79:0]            tv;
  logic                   hit;
  logic [31:0]            aoz;
  logic [31:0]            adz;
  logic                   sz;
  logic                   sdz;

  assign en       = !v2[DIV_STAGES-1] || !res_full;
  assign mid_pop  = en && !mid_empty;
  assign res_push = en && v2[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      v1    <= '0;
      m_vld <= 1'b0;
      v2    <= '0;
    end else if (en) begin
      a_vld <= !mid_empty;
      b_vld <= a_vld;
      v1    <= {v1[SQRT_STAGES-2:0], b_vld};
      m_vld <= v1[SQRT_STAGES-1];
      v2    <= {v2[DIV_STAGES-2:0], m_vld};
    end
  end

  assign aoz = abs32(a.po_z);
  assign adz = abs32(a.pd_z);
  assign sz  = a.po_z[31];
  assign sdz = a.pd_z[31];

  always_ff @(posedge clk) begin
    if (en) begin
      a <= mid;

      b.miss       <= a.miss;
      b.o_x        <= a.ray.origin_x;
      b.o_y        <= a.ray.origin_y;
      b.o_z        <= a.ray.origin_z;
      b.po_x       <= a.po_x;
      b.po_y       <= a.po_y;
      b.aoz        <= aoz;
      b.adz        <= adz;
      b.num[Q_X]   <= mul_u32(aoz, abs32(a.pd_x));
      b.num[Q_Y]   <= mul_u32(aoz, abs32(a.pd_y));
      b.num[Q_HX]  <= mul_u32(aoz, abs32(a.ray.dir_x));
      b.num[Q_HY]  <= mul_u32(aoz, abs32(a.ray.dir_y));
      b.num[Q_HZ]  <= mul_u32(aoz, abs32(a.ray.dir_z));
      b.neg[Q_X]   <= sz ^ a.pd_x[31] ^ sdz;
      b.neg[Q_Y]   <= sz ^ a.pd_y[31] ^ sdz;
      b.neg[Q_HX]  <= !sz ^ a.ray.dir_x[31] ^ sdz;
      b.neg[Q_HY]  <= !sz ^ a.ray.dir_y[31] ^ sdz;
      b.neg[Q_HZ]  <= !sz ^ a.ray.dir_z[31] ^ sdz;
      b_sq[0]      <= mul_u32(abs32(a.ray.dir_x), abs32(a.ray.dir_x));
      b_sq[1]      <= mul_u32(abs32(a.ray.dir_y), abs32(a.ray.dir_y));
      b_sq[2]      <= mul_u32(abs32(a.ray.dir_z), abs32(a.ray.dir_z));

      s1[0] <= b;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        s1[k] <= s1[k-1];
      end

      m.miss <= s1[SQRT_STAGES-1].miss;
      m.o_x  <= s1[SQRT_STAGES-1].o_x;
      m.o_y  <= s1[SQRT_STAGES-1].o_y;
      m.o_z  <= s1[SQRT_STAGES-1].o_z;
      m.po_x <= s1[SQRT_STAGES-1].po_x;
      m.po_y <= s1[SQRT_STAGES-1].po_y;
      m.neg  <= s1[SQRT_STAGES-1].neg;
      for (int q = 0; q < NUM_QUO - 1; q++) begin
        m_num[q] <= s1[SQRT_STAGES-1].num[q];
      end
      m_num[Q_DIST] <= mul_u32(s1[SQRT_STAGES-1].aoz, root);
      m_den         <= s1[SQRT_STAGES-1].adz;

      s2[0] <= m;
      for (int k = 1; k < DIV_STAGES; k++) begin
        s2[k] <= s2[k-1];
      end
    end
  end

  assign rad = b_sq[0] + b_sq[1] + b_sq[2];

  rusi_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad),
    .root (root)
  );

  for (genvar q = 0; q < NUM_QUO; q++) begin : g_div
    rusi_div u_div (
      .clk (clk),
      .en  (en),
      .num (m_num[q]),
      .den (m_den),
      .quo (quo[q])
    );
  end

  assign t = s2[DIV_STAGES-1];

  always_comb begin
    for (int q = 0; q < NUM_QUO - 1; q++) begin
      qs[q] = t.neg[q] ? -$signed(quo[q]) : $signed(quo[q]);
    end
    x   = 64'(t.po_x) - qs[Q_X];
    y   = 64'(t.po_y) - qs[Q_Y];
    hit = !t.miss && !((x > HALF) || (x < -HALF) || (y > HALF) || (y < -HALF));
    tu  = {x + HALF, 16'b0} >> FRAC_BITS;
    tv  = {y + HALF, 16'b0} >> FRAC_BITS;
    res = '0;
    if (hit) begin
      res.hit      = 1'b1;
      res.distance = (quo[Q_DIST] > 64'h7fffffff) ? 31'h7fffffff : quo[Q_DIST][30:0];
      res.hit_x    = sat32(64'(t.o_x) + qs[Q_HX]);
      res.hit_y    = sat32(64'(t.o_y) + qs[Q_HY]);
      res.hit_z    = sat32(64'(t.o_z) + qs[Q_HZ]);
      res.norm_x   = normal.x;
      res.norm_y   = normal.y;
      res.norm_z   = normal.z;
      res.tex_u    = tu[16:0];
      res.tex_v    = tv[16:0];
    end
  end

endmodule

// ===== src/ray_unit_square_intersect.sv =====
// Ray against unit square intersection block.
// One ray per cycle is sustained while results are popped; the pipeline holds the 64-stage dividers and 32-stage root.
// Reset empties both queues and the pipelines, sets the transform to identity
// and the normal to (0,0,1).
// Depends on rusi_pkg, rusi_front, rusi_queue and rusi_back.
module ray_unit_square_intersect import rusi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  ray_t                  ray,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

  logic [CFG_DATA_W-1:0] cfg_reg [NUM_CFG];
  mat_t                  mat;
  normal_t               normal;
  logic                  mid_push;
  logic                  mid_full;
  mid_t                  mid_w;
  mid_t                  mid_r;
  logic                  mid_empty;
  logic                  mid_pop;
  logic                  res_push;
  logic                  res_full;
  result_t               res_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg[CFG_ROW0_A]    <= {ONE_FX, 32'b0};
      cfg_reg[CFG_ROW0_B]    <= '0;
      cfg_reg[CFG_ROW1_A]    <= {32'b0, ONE_FX};
      cfg_reg[CFG_ROW1_B]    <= '0;
      cfg_reg[CFG_ROW2_A]    <= '0;
      cfg_reg[CFG_ROW2_B]    <= {ONE_FX, 32'b0};
      cfg_reg[CFG_NORMAL_XY] <= '0;
      cfg_reg[CFG_NORMAL_Z]  <= {32'b0, ONE_FX};
    end else if (cfg_write) begin
      cfg_reg[cfg_index] <= (cfg_index == CFG_NORMAL_Z) ? {32'b0, cfg_data[31:0]} : cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mat[r][0] = cfg_reg[CFG_IDX_W'(2 * r)][63:32];
      mat[r][1] = cfg_reg[CFG_IDX_W'(2 * r)][31:0];
      mat[r][2] = cfg_reg[CFG_IDX_W'(2 * r + 1)][63:32];
      mat[r][3] = cfg_reg[CFG_IDX_W'(2 * r + 1)][31:0];
    end
  end

  assign normal.x = $signed(cfg_reg[CFG_NORMAL_XY][63:32]);
  assign normal.y = $signed(cfg_reg[CFG_NORMAL_XY][31:0]);
  assign normal.z = $signed(cfg_reg[CFG_NORMAL_Z][31:0]);

  rusi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .ray      (ray),
    .mat      (mat),
    .mid_push (mid_push),
    .mid      (mid_w),
    .mid_full (mid_full)
  );

  rusi_queue #(.WIDTH($bits(mid_t)), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_w),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_r),
    .empty (mid_empty)
  );

  rusi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid       (mid_r),
    .mid_pop   (mid_pop),
    .normal    (normal),
    .res_push  (res_push),
    .res       (res_w),
    .res_full  (res_full)
  );

  rusi_queue #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_w),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== test/tb_ray_unit_square_intersect.sv =====
// Testbench for ray_unit_square_intersect: random and directed rays with a bit-exact predictor.
// Checks each popped result against the oldest predicted one under several transform settings.
// Depends on rusi_pkg and the ray_unit_square_intersect RTL.
module tb_ray_unit_square_intersect;
  import rusi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] ONE_FX  = 64'sd65536;
  localparam logic signed [63:0] HALF_FX = 64'sd32768;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  ray_t ray = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [63:0] cfg_shadow [NUM_CFG];
  ray_t pending_rays [$];
  result_t expected_results [$];
  int errors = 0;
  int cycles = 0;
  int rays_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  ray_unit_square_intersect u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .ray(ray),
    .empty(empty), .pop(pop), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] sext(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic result_t square_hit(ray_t rr);
    logic signed [63:0] o [3];
    logic signed [63:0] d [3];
    logic signed [63:0] m [3][4];
    logic signed [63:0] po [3];
    logic signed [63:0] pd [3];
    logic signed [63:0] so, sd, oz, dz, x, y, hk;
    logic [63:0] len, span, aoz, adz;
    result_t res;
    res = '0;
    o[0] = sext(rr.origin_x); o[1] = sext(rr.origin_y); o[2] = sext(rr.origin_z);
    d[0] = sext(rr.dir_x);    d[1] = sext(rr.dir_y);    d[2] = sext(rr.dir_z);
    for (int r = 0; r < 3; r++) begin
      m[r][0] = sext(cfg_shadow[2*r][63:32]);
      m[r][1] = sext(cfg_shadow[2*r][31:0]);
      m[r][2] = sext(cfg_shadow[2*r+1][63:32]);
      m[r][3] = sext(cfg_shadow[2*r+1][31:0]);
      so = m[r][3];
      sd = 0;
      for (int c = 0; c < 3; c++) begin
        so = so + ((m[r][c] * o[c]) >>> 16);
        sd = sd + ((m[r][c] * d[c]) >>> 16);
      end
      po[r] = clamp32(so);
      pd[r] = clamp32(sd);
    end
    oz = po[2];
    dz = pd[2];
    if (dz == 0) return res;
    if ((oz > 0 && dz > 0) || (oz < 0 && dz < 0)) return res;
    x = po[0] - (oz * pd[0]) / dz;
    y = po[1] - (oz * pd[1]) / dz;
    if (x > HALF_FX || x < -HALF_FX || y > HALF_FX || y < -HALF_FX) return res;
    hk = clamp32(o[0] + ((-oz) * d[0]) / dz); res.hit_x = hk[31:0];
    hk = clamp32(o[1] + ((-oz) * d[1]) / dz); res.hit_y = hk[31:0];
    hk = clamp32(o[2] + ((-oz) * d[2]) / dz); res.hit_z = hk[31:0];
    len = root64(64'(d[0] * d[0]) + 64'(d[1] * d[1]) + 64'(d[2] * d[2]));
    aoz = oz < 0 ? 64'(-oz) : 64'(oz);
    adz = dz < 0 ? 64'(-dz) : 64'(dz);
    span = (aoz * len) / adz;
    if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
    res.hit = 1'b1;
    res.distance = span[30:0];
    res.norm_x = cfg_shadow[CFG_NORMAL_XY][63:32];
    res.norm_y = cfg_shadow[CFG_NORMAL_XY][31:0];
    res.norm_z = cfg_shadow[CFG_NORMAL_Z][31:0];
    hk = x + HALF_FX; res.tex_u = hk[16:0];
    hk = y + HALF_FX; res.tex_v = hk[16:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(square_hit(ray));
        rays_sent++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_rays.size() > 0) begin
        push <= 1'b1;
        ray <= pending_rays.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes mode after a random hold.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (result.hit) hits_seen++;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          result_t exp_r;
          exp_r = expected_results.pop_front();
          check_field("hit", exp_r.hit, result.hit);
          check_field("distance", exp_r.distance, result.distance);
          check_field("hit_x", exp_r.hit_x, result.hit_x);
          check_field("hit_y", exp_r.hit_y, result.hit_y);
          check_field("hit_z", exp_r.hit_z, result.hit_z);
          check_field("norm_x", exp_r.norm_x, result.norm_x);
          check_field("norm_y", exp_r.norm_y, result.norm_y);
          check_field("norm_z", exp_r.norm_z, result.norm_z);
          check_field("tex_u", exp_r.tex_u, result.tex_u);
          check_field("tex_v", exp_r.tex_v, result.tex_v);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(10, 80);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        2: pop <= ($urandom_range(0, 7) == 0);
        default: pop <= (cycles % 3) != 0;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ray_unit_square_intersect] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_shadow[idx] = (idx == CFG_NORMAL_Z) ? {32'd0, val[31:0]} : val;
  endtask

  task automatic wait_idle();
    while (pending_rays.size() > 0 || push || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_ray(logic signed [63:0] ox, oy, oz, dx, dy, dz);
    ray_t rr;
    rr.origin_x = ox[31:0]; rr.origin_y = oy[31:0]; rr.origin_z = oz[31:0];
    rr.dir_x = dx[31:0];    rr.dir_y = dy[31:0];    rr.dir_z = dz[31:0];
    pending_rays.push_back(rr);
  endtask

  // Aims rays at points of the square assuming a mostly diagonal transform; about one in four is random instead.
  task automatic add_aimed_rays(int count);
    logic signed [63:0] s [3];
    logic signed [63:0] t [3];
    logic signed [63:0] w [3];
    logic signed [63:0] org [3];
    logic signed [63:0] objp [3];
    ray_t rr;
    for (int k = 0; k < 3; k++) begin
      s[k] = sext(k == 2 ? cfg_shadow[2*k+1][63:32] :
                  (k == 0 ? cfg_shadow[0][63:32] : cfg_shadow[2][31:0]));
      t[k] = sext(cfg_shadow[2*k+1][31:0]);
      if (s[k] == 0) s[k] = ONE_FX;
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        rr = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 1)) begin
          rr.origin_x = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
          rr.dir_y = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
        end
        pending_rays.push_back(rr);
      end else begin
        objp[0] = $signed($urandom_range(0, 36000)) - 64'sd18000;
        objp[1] = $signed($urandom_range(0, 36000)) - 64'sd18000;
        objp[2] = 0;
        for (int k = 0; k < 3; k++) begin
          w[k] = ((objp[k] - t[k]) <<< 16) / s[k];
          org[k] = w[k] + $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        end
        add_ray(org[0], org[1], org[2], w[0] - org[0], w[1] - org[1], w[2] - org[2]);
      end
    end
  endtask

  task automatic random_transform();
    logic [31:0] e [3][4];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r == c) begin
          e[r][c] = $urandom_range(32768, 131072);
          if ($urandom_range(0, 1)) e[r][c] = -e[r][c];
        end else begin
          e[r][c] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8192) - 4096 : 0;
        end
      end
      e[r][3] = $urandom_range(0, 2 << 16) - (1 << 16);
      write_reg(CFG_IDX_W'(2*r), {e[r][0], e[r][1]});
      write_reg(CFG_IDX_W'(2*r+1), {e[r][2], e[r][3]});
    end
    write_reg(CFG_NORMAL_XY, {$urandom, $urandom});
    write_reg(CFG_NORMAL_Z, {$urandom, $urandom});
  endtask

  initial begin
    cfg_shadow[CFG_ROW0_A] = 64'(ONE_FX) << 32;
    cfg_shadow[CFG_ROW0_B] = 0;
    cfg_shadow[CFG_ROW1_A] = 64'(ONE_FX);
    cfg_shadow[CFG_ROW1_B] = 0;
    cfg_shadow[CFG_ROW2_A] = 0;
    cfg_shadow[CFG_ROW2_B] = 64'(ONE_FX) << 32;
    cfg_shadow[CFG_NORMAL_XY] = 0;
    cfg_shadow[CFG_NORMAL_Z] = 64'(ONE_FX);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rays under the reset transform: edges, parallel, behind, on plane, extremes.
    add_ray(0, 0, ONE_FX, 0, 0, -ONE_FX);
    add_ray(HALF_FX, HALF_FX, ONE_FX, 0, 0, -ONE_FX);
    add_ray(-HALF_FX, -HALF_FX, ONE_FX, 0, 0, -ONE_FX);
    add_ray(HALF_FX + 1, 0, ONE_FX, 0, 0, -ONE_FX);
    add_ray(0, -HALF_FX - 1, ONE_FX, 0, 0, -ONE_FX);
    add_ray(0, 0, ONE_FX, ONE_FX, 0, 0);
    add_ray(0, 0, ONE_FX, 0, 0, ONE_FX);
    add_ray(0, 0, -ONE_FX, 0, 0, -ONE_FX);
    add_ray(0, 0, -ONE_FX, 0, 0, ONE_FX);
    add_ray(100, -200, 0, 5, 7, ONE_FX);
    add_ray(0, 0, 0, 0, 0, 0);
    add_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
            -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    add_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
            64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
    add_ray(0, 0, 64'sd2147483647, 0, 0, -1);
    add_ray(0, 0, -64'sd2147483648, 0, 0, 64'sd2147483647);
    add_ray(0, 0, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648);
    add_ray(HALF_FX, -HALF_FX, 1, 0, 0, -64'sd2147483648);
    add_aimed_rays(250);
    wait_idle();

    write_reg(CFG_ROW0_A, '1); write_reg(CFG_ROW0_B, '1);
    write_reg(CFG_ROW1_A, '1); write_reg(CFG_ROW1_B, '1);
    write_reg(CFG_ROW2_A, '1); write_reg(CFG_ROW2_B, '1);
    write_reg(CFG_NORMAL_XY, '1); write_reg(CFG_NORMAL_Z, '1);
    add_aimed_rays(60);
    wait_idle();

    for (int k = 0; k < NUM_CFG; k++) write_reg(CFG_IDX_W'(k), 64'h8000_0000_8000_0000);
    add_aimed_rays(60);
    wait_idle();

    for (int k = 0; k < NUM_CFG; k++) write_reg(CFG_IDX_W'(k), 64'h7FFF_FFFF_7FFF_FFFF);
    add_aimed_rays(40);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      random_transform();
      add_aimed_rays(140);
      wait_idle();
    end

    $display("Sent %0d rays over nine register settings; %0d results checked, %0d hits.",
             rays_sent, results_seen, hits_seen);
    if (errors == 0) begin
      $display("[ray_unit_square_intersect] OK");
    end else begin
      $display("[ray_unit_square_intersect] ERROR");
    end
    $finish;
  end
endmodule

// ===== ray_unit_square_intersect.f =====
src/rusi_pkg.sv
src/rusi_queue.sv
src/rusi_div.sv
src/rusi_sqrt.sv
src/rusi_front.sv
src/rusi_back.sv
src/ray_unit_square_intersect.sv
test/tb_ray_unit_square_intersect.sv
